/* src/rcpe_pkg.sv */
// ----------------------------------------------------------------------------
// rcpe_pkg - shared types and constants of the RLE cel pixel expander
// Payload structs, register indexes, the decode enumerations and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rcpe_pkg;

   localparam int CSR_DATA_BITS = 10;

   typedef enum logic [2:0] {
      CSR_FORMAT_MODE   = 3'd0,
      CSR_START_X       = 3'd1,
      CSR_START_Y       = 3'd2,
      CSR_PORT_TOP      = 3'd3,
      CSR_PORT_BOTTOM   = 3'd4,
      CSR_DRAW_PRIORITY = 3'd5,
      CSR_SCREEN_WIDTH  = 3'd6
   } csr_index_type;

   localparam logic [9:0] PORT_BOTTOM_RESET  = 10'd200;
   localparam logic [9:0] SCREEN_WIDTH_RESET = 10'd320;

   // Header layout: eight bytes, height little endian in bytes 2 and 3.
   localparam logic [3:0] HEADER_BYTES     = 4'd8;
   localparam logic [3:0] HEADER_LAST      = 4'd7;
   localparam logic [3:0] HEADER_HEIGHT_LO = 4'd2;
   localparam logic [3:0] HEADER_HEIGHT_HI = 4'd3;
   localparam logic [3:0] HEADER_CLEAR     = 4'd6;

   // PC run code classes, taken from bits 7..6 of the code byte.
   localparam logic [1:0] PC_LITERAL = 2'b00;
   localparam logic [1:0] PC_UNUSED  = 2'b01;
   localparam logic [1:0] PC_FILL    = 2'b10;
   localparam logic [1:0] PC_SKIP    = 2'b11;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
      logic [7:0] pixel_color;
      logic [7:0] pixel_priority;
      logic       run_end;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      PH_CODE    = 2'd0,
      PH_LITERAL = 2'd1,
      PH_FILL    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_FILL = 2'd1,
      ACT_SKIP = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_DECODE   = 3'd1,
      ST_HDR_LOAD = 3'd2,
      ST_HDR_MIN  = 3'd3,
      ST_HDR_SAT  = 3'd4,
      ST_FILL     = 3'd5,
      ST_SKIP     = 3'd6,
      ST_FINISH   = 3'd7
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic hdr_write;
      logic decode;
      logic load_cursor;
      logic limit_min;
      logic limit_sat;
      logic step_fill;
      logic skip;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic       hdr_mode;
      logic       hdr_end;
      logic       done;
      action_type act;
      logic       fill_more;
      logic       out_free;
   } dp_status_type;

endpackage

/* src/rcpe_ctrl.sv */
// ----------------------------------------------------------------------------
// rcpe_ctrl - sequencer of the RLE cel pixel expander
// Takes one request at a time and steps the datapath through header
// handling, run decoding, pixel filling, skipping and end-of-byte update.
// ----------------------------------------------------------------------------
module rcpe_ctrl
   import rcpe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.hdr_mode) begin
               state_in = status.hdr_end ? ST_HDR_LOAD : ST_FINISH;
            end else if (status.done) begin
               state_in = ST_FINISH;
            end else begin
               case (status.act)
                  ACT_FILL: state_in = ST_FILL;
                  ACT_SKIP: state_in = ST_SKIP;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_HDR_LOAD: state_in = ST_HDR_MIN;
         ST_HDR_MIN:  state_in = ST_HDR_SAT;
         ST_HDR_SAT:  state_in = ST_FINISH;
         ST_FILL: begin
            if (!status.fill_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_SKIP:   state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.latch = req_valid;
         end
         ST_DECODE: begin
            cmd.hdr_write = status.hdr_mode;
            cmd.decode    = !status.hdr_mode && !status.done;
         end
         ST_HDR_LOAD: cmd.load_cursor = 1'b1;
         ST_HDR_MIN:  cmd.limit_min   = 1'b1;
         ST_HDR_SAT:  cmd.limit_sat   = 1'b1;
         // A pixel goes out only when the result register can take it.
         ST_FILL:     cmd.step_fill   = status.fill_more && status.out_free;
         ST_SKIP:     cmd.skip        = 1'b1;
         ST_FINISH:   cmd.finish      = 1'b1;
         default:     cmd             = '0;
      endcase
   end

endmodule

/* src/rcpe_dp.sv */
// ----------------------------------------------------------------------------
// rcpe_dp - datapath of the RLE cel pixel expander
// Holds the configuration, header fields, cursor, run state and the result
// register, and carries out the commands of the sequencer.
// ----------------------------------------------------------------------------
module rcpe_dp
   import rcpe_pkg::*;
#(
   parameter int COORD_BITS = 10
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  req_payload_type          req_payload,
   input  logic                     csr_write_enable,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   output logic                     rsp_valid,
   output rsp_payload_type          rsp_payload,
   input  logic                     rsp_stall
);

   localparam int CW = (COORD_BITS > 10) ? COORD_BITS : 10;
   localparam int AW = CW + 1;
   localparam int LW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
   localparam logic [COORD_BITS-1:0] CMAX = {COORD_BITS{1'b1}};

   // Configuration registers.
   logic       format_ff;
   logic [9:0] start_x_ff;
   logic [9:0] start_y_ff;
   logic [9:0] port_top_ff;
   logic [9:0] port_bottom_ff;
   logic [7:0] priority_ff;
   logic [9:0] screen_width_ff;

   // Control state.
   logic [3:0]            header_index_ff, header_index_in;
   phase_type             phase_ff, phase_in;
   logic [5:0]            run_left_ff, run_left_in;
   logic                  cel_done_ff, cel_done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           cel_height_ff, cel_height_in;
   logic [7:0]            clear_ff, clear_in;
   logic [COORD_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0] cursor_y_ff, cursor_y_in;
   logic [COORD_BITS-1:0] row_limit_ff, row_limit_in;

   // Working registers of the current request.
   logic [7:0]      byte_ff;
   logic            last_ff;
   logic [5:0]      fill_cnt_ff, fill_cnt_in;
   logic [7:0]      color_ff;
   logic [5:0]      skip_ff;
   logic [9:0]      limit_mid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Decode of the latched byte.
   action_type dec_act;
   phase_type  dec_phase;
   logic [5:0] dec_run_left;
   logic [5:0] dec_cnt;
   logic [7:0] dec_color;
   logic [5:0] dec_skip;
   logic [5:0] run_left_m1;

   // Shared cursor advance.
   logic [5:0]            adv_n;
   logic [AW-1:0]         adv_sum;
   logic                  adv_wrap;
   logic [AW-1:0]         adv_x_full;
   logic [COORD_BITS-1:0] adv_y;

   logic [CW-1:0]         start_x_ext;
   logic [LW-1:0]         load_y_sum;
   logic [COORD_BITS-1:0] load_y;
   logic [LW-1:0]         min_sum;
   logic [9:0]            min_val;
   logic [LW-1:0]         sat_sum;
   logic [COORD_BITS-1:0] sat_val;
   logic [CW-1:0]         x_ext;
   logic [CW-1:0]         y_ext;
   logic                  out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff       <= 1'b0;
         start_x_ff      <= '0;
         start_y_ff      <= '0;
         port_top_ff     <= '0;
         port_bottom_ff  <= PORT_BOTTOM_RESET;
         priority_ff     <= '0;
         screen_width_ff <= SCREEN_WIDTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FORMAT_MODE:   format_ff       <= csr_write_data[0];
            CSR_START_X:       start_x_ff      <= csr_write_data;
            CSR_START_Y:       start_y_ff      <= csr_write_data;
            CSR_PORT_TOP:      port_top_ff     <= csr_write_data;
            CSR_PORT_BOTTOM:   port_bottom_ff  <= csr_write_data;
            CSR_DRAW_PRIORITY: priority_ff     <= csr_write_data[7:0];
            CSR_SCREEN_WIDTH:  screen_width_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      dec_act      = ACT_NONE;
      dec_phase    = phase_ff;
      dec_run_left = run_left_ff;
      dec_cnt      = 6'd1;
      dec_color    = byte_ff;
      dec_skip     = 6'd1;
      run_left_m1  = run_left_ff - 6'd1;
      case (phase_ff)
         PH_LITERAL: begin
            // A literal equal to the clear colour only moves the cursor.
            dec_act      = (byte_ff != clear_ff) ? ACT_FILL : ACT_SKIP;
            dec_run_left = run_left_m1;
            dec_phase    = (run_left_m1 == 6'd0) ? PH_CODE : PH_LITERAL;
         end
         PH_FILL: begin
            dec_act      = ACT_FILL;
            dec_cnt      = run_left_ff;
            dec_run_left = 6'd0;
            dec_phase    = PH_CODE;
         end
         default: begin
            if (format_ff) begin
               dec_color = {3'd0, byte_ff[7:3]};
               dec_cnt   = {3'd0, byte_ff[2:0]};
               dec_skip  = {1'b0, byte_ff[7:3]};
               dec_act   = (byte_ff[2:0] != 3'd0) ? ACT_FILL : ACT_SKIP;
            end else begin
               case (byte_ff[7:6])
                  PC_LITERAL: begin
                     if (byte_ff[5:0] != 6'd0) begin
                        dec_run_left = byte_ff[5:0];
                        dec_phase    = PH_LITERAL;
                     end
                  end
                  PC_FILL: begin
                     dec_run_left = byte_ff[5:0];
                     dec_phase    = PH_FILL;
                  end
                  PC_SKIP: begin
                     dec_act  = ACT_SKIP;
                     dec_skip = byte_ff[5:0];
                  end
                  default: dec_act = ACT_NONE;
               endcase
            end
         end
      endcase
   end

   // Cursor advance: x wraps by one screen width at most once.
   always_comb begin
      adv_n      = cmd.step_fill ? 6'd1 : skip_ff;
      adv_sum    = AW'(cursor_x_ff) + AW'(adv_n);
      adv_wrap   = adv_sum >= AW'(screen_width_ff);
      adv_x_full = adv_wrap ? (adv_sum - AW'(screen_width_ff)) : adv_sum;
      adv_y      = (adv_wrap && (cursor_y_ff != CMAX)) ?
                   (cursor_y_ff + COORD_BITS'(1)) : cursor_y_ff;
   end

   always_comb begin
      start_x_ext = CW'(start_x_ff);
      load_y_sum  = LW'(start_y_ff) + LW'(port_top_ff);
      load_y      = (load_y_sum > LW'(CMAX)) ? CMAX : load_y_sum[COORD_BITS-1:0];
      min_sum     = LW'(cel_height_ff) + LW'(cursor_y_ff);
      min_val     = (min_sum < LW'(port_bottom_ff)) ? min_sum[9:0] : port_bottom_ff;
      // Port top is added a second time here, as the format expects.
      sat_sum     = LW'(limit_mid_ff) + LW'(port_top_ff);
      sat_val     = (sat_sum > LW'(CMAX)) ? CMAX : sat_sum[COORD_BITS-1:0];
      x_ext       = CW'(cursor_x_ff);
      y_ext       = CW'(cursor_y_ff);
      out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      header_index_in = header_index_ff;
      phase_in        = phase_ff;
      run_left_in     = run_left_ff;
      cel_done_in     = cel_done_ff;
      cel_height_in   = cel_height_ff;
      clear_in        = clear_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      row_limit_in    = row_limit_ff;
      fill_cnt_in     = fill_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_payload_in  = rsp_payload_ff;

      if (cmd.hdr_write) begin
         case (header_index_ff)
            HEADER_HEIGHT_LO: cel_height_in[7:0]  = byte_ff;
            HEADER_HEIGHT_HI: cel_height_in[15:8] = byte_ff;
            HEADER_CLEAR:     clear_in            = byte_ff;
            default: ;
         endcase
         header_index_in = header_index_ff + 4'd1;
      end
      if (cmd.decode) begin
         phase_in    = dec_phase;
         run_left_in = dec_run_left;
         fill_cnt_in = dec_cnt;
      end
      if (cmd.load_cursor) begin
         cursor_x_in = start_x_ext[COORD_BITS-1:0];
         cursor_y_in = load_y;
         phase_in    = PH_CODE;
         run_left_in = 6'd0;
      end
      if (cmd.limit_sat) begin
         row_limit_in = sat_val;
      end
      if (cmd.step_fill || cmd.skip) begin
         cursor_x_in = adv_x_full[COORD_BITS-1:0];
         cursor_y_in = adv_y;
      end
      if (cmd.step_fill) begin
         fill_cnt_in                   = fill_cnt_ff - 6'd1;
         rsp_valid_in                  = 1'b1;
         rsp_payload_in.pixel_x        = x_ext[9:0];
         rsp_payload_in.pixel_y        = y_ext[9:0];
         rsp_payload_in.pixel_color    = color_ff;
         rsp_payload_in.pixel_priority = priority_ff;
         // Last pixel of the request when the count runs out or the cel ends.
         rsp_payload_in.run_end        = (fill_cnt_ff == 6'd1) || (adv_y >= row_limit_ff);
      end
      if (cmd.finish) begin
         if ((header_index_ff == HEADER_BYTES) && (cursor_y_ff >= row_limit_ff)) begin
            cel_done_in = 1'b1;
         end
         if (last_ff) begin
            header_index_in = '0;
            phase_in        = PH_CODE;
            run_left_in     = 6'd0;
            cel_done_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_index_ff <= '0;
         phase_ff        <= PH_CODE;
         run_left_ff     <= '0;
         cel_done_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cel_height_ff   <= '0;
         clear_ff        <= '0;
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         row_limit_ff    <= '0;
      end else begin
         header_index_ff <= header_index_in;
         phase_ff        <= phase_in;
         run_left_ff     <= run_left_in;
         cel_done_ff     <= cel_done_in;
         rsp_valid_ff    <= rsp_valid_in;
         cel_height_ff   <= cel_height_in;
         clear_ff        <= clear_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         row_limit_ff    <= row_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         byte_ff <= req_payload.data_byte;
         last_ff <= req_payload.last_byte;
      end
      if (cmd.decode) begin
         color_ff <= dec_color;
         skip_ff  <= dec_skip;
      end
      if (cmd.limit_min) begin
         limit_mid_ff <= min_val;
      end
      fill_cnt_ff    <= fill_cnt_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      status.hdr_mode  = header_index_ff < HEADER_BYTES;
      status.hdr_end   = header_index_ff == HEADER_LAST;
      status.done      = cel_done_ff;
      status.act       = dec_act;
      status.fill_more = (fill_cnt_ff != 6'd0) && (cursor_y_ff < row_limit_ff);
      status.out_free  = out_free;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   a_fill_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.step_fill |-> out_free)
      else $error("pixel produced while the result register is held");

   a_fill_inside_port: assert property (@(posedge clock) disable iff (reset)
      cmd.step_fill |-> (cursor_y_ff < row_limit_ff))
      else $error("pixel produced at or below the row limit");

   a_header_index_range: assert property (@(posedge clock) disable iff (reset)
      header_index_ff <= HEADER_BYTES)
      else $error("header index past the end of the header");

   a_done_after_header: assert property (@(posedge clock) disable iff (reset)
      cel_done_ff |-> (header_index_ff == HEADER_BYTES))
      else $error("cel marked done before its header completed");
`endif

endmodule

/* src/rle_cel_pixel_expander_unit.sv */
// ----------------------------------------------------------------------------
// rle_cel_pixel_expander_unit - run-length cel to pixel write expander
// Parses an eight-byte cel header, then expands PC or Amiga run codes into
// pixel writes with position, colour and priority.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Carries
//   req_      in         req_valid / req_stall     one cel byte and end flag
//   rsp_      out        rsp_valid / rsp_stall     one pixel write
//   csr_      in         csr_write_enable          register index and data
//
// Requests are taken one at a time: a header byte is latched, decoded and
// finished, the last also loads the cursor and forms the row limit, a run
// code with no pixels may move the cursor, and a pixel byte gets one pixel a
// cycle out of the shared cursor adder, held while the result is stalled.
// Reset is synchronous; it clears the sequencer, the cursor and the header
// state and loads the register defaults; no clearing pass is needed.
//
module rle_cel_pixel_expander_unit
   import rcpe_pkg::*;
#(
   parameter int COORD_BITS = 10
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_payload_type          req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_payload_type          rsp_payload,
   input  logic                     csr_write_enable,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   rcpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rcpe_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .rsp_stall        (rsp_stall)
   );

endmodule

/* dv/rle_cel_pixel_write_checker.sv */
// ----------------------------------------------------------------------------
// rle_cel_pixel_write_checker - pixel write predictor and scoreboard
// Watches the request, result and register ports of the cel expander, keeps
// its own copy of the registers and the decode state, works out the pixel
// writes that every accepted request causes and compares each accepted
// result, field by field, with the oldest write still due.
// ----------------------------------------------------------------------------
module rle_cel_pixel_write_checker
   import rcpe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  req_payload_type          req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rsp_payload_type          rsp_payload,
   input  logic                     csr_write_enable,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data,
   output int                       mismatches,
   output int                       writes_due
);

   localparam int unsigned COORD_MAX = 1023;

   // Register copy.
   logic        fmt_amiga;
   int unsigned org_x, org_y, top_row, bottom_row, row_width;
   logic [7:0]  prio;

   // Decode state.
   logic [3:0]  hdr_count;
   logic [15:0] height;
   logic [7:0]  clear_idx;
   int unsigned cur_x, cur_y, last_row;
   phase_type   phase;
   logic [5:0]  run_count;
   logic        drawing_done;

   rsp_payload_type pixel_writes_due[$];

   function automatic int unsigned clamp_coord(input int unsigned v);
      return (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   task automatic load_cursor();
      cur_x = org_x & COORD_MAX;
      cur_y = clamp_coord(org_y + top_row);
   endtask

   task automatic rearm();
      hdr_count    = '0;
      phase        = PH_CODE;
      run_count    = '0;
      drawing_done = 1'b0;
   endtask

   // The cursor wraps by one screen width at most once per move.
   task automatic step_cursor(input int unsigned n);
      int unsigned nx;
      nx = cur_x + n;
      if (nx >= row_width) begin
         nx = nx - row_width;
         if (cur_y < COORD_MAX) cur_y++;
      end
      cur_x = nx & COORD_MAX;
   endtask

   task automatic queue_pixel(input logic [7:0] color);
      rsp_payload_type w;
      w.pixel_x        = 10'(cur_x);
      w.pixel_y        = 10'(cur_y);
      w.pixel_color    = color;
      w.pixel_priority = prio;
      w.run_end        = 1'b0;
      pixel_writes_due.push_back(w);
   endtask

   task automatic paint_run(input int unsigned n, input logic [7:0] color);
      while (n > 0 && cur_y < last_row) begin
         queue_pixel(color);
         step_cursor(1);
         n--;
      end
   endtask

   task automatic decode_code(input logic [7:0] b);
      if (fmt_amiga) begin
         if (b[2:0] != 3'd0) paint_run(32'(b[2:0]), {3'b000, b[7:3]});
         else step_cursor(32'(b[7:3]));
      end else begin
         case (b[7:6])
            PC_LITERAL: begin
               if (b[5:0] != 6'd0) begin
                  run_count = b[5:0];
                  phase     = PH_LITERAL;
               end
            end
            PC_FILL: begin
               run_count = b[5:0];
               phase     = PH_FILL;
            end
            PC_SKIP: step_cursor(32'(b[5:0]));
            default: ;
         endcase
      end
   endtask

   task automatic take_header(input logic [7:0] b);
      int unsigned sum;
      case (hdr_count)
         HEADER_HEIGHT_LO: height[7:0]  = b;
         HEADER_HEIGHT_HI: height[15:8] = b;
         HEADER_CLEAR:     clear_idx    = b;
         default: ;
      endcase
      hdr_count++;
      if (hdr_count == HEADER_BYTES) begin
         load_cursor();
         sum = 32'(height) + cur_y;
         if (sum > bottom_row) sum = bottom_row;
         // The port top goes in twice, once via the cursor and once here.
         last_row     = clamp_coord(sum + top_row);
         phase        = PH_CODE;
         run_count    = '0;
         drawing_done = (cur_y >= last_row);
      end
   endtask

   task automatic take_data(input logic [7:0] b);
      if (drawing_done) return;
      case (phase)
         PH_LITERAL: begin
            if (b != clear_idx) queue_pixel(b);
            step_cursor(1);
            run_count--;
            if (run_count == 6'd0) phase = PH_CODE;
         end
         PH_FILL: begin
            paint_run(32'(run_count), b);
            run_count = '0;
            phase     = PH_CODE;
         end
         default: decode_code(b);
      endcase
      if (cur_y >= last_row) drawing_done = 1'b1;
   endtask

   task automatic expand_byte(input req_payload_type r);
      int              before_count;
      rsp_payload_type w;
      before_count = pixel_writes_due.size();
      if (hdr_count < HEADER_BYTES) take_header(r.data_byte);
      else take_data(r.data_byte);
      if (r.last_byte) rearm();
      if (pixel_writes_due.size() > before_count) begin
         w = pixel_writes_due.pop_back();
         w.run_end = 1'b1;
         pixel_writes_due.push_back(w);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type w;
      if (reset) begin
         mismatches = 0;
         fmt_amiga  = 1'b0;
         org_x      = 0;
         org_y      = 0;
         top_row    = 0;
         bottom_row = 32'(PORT_BOTTOM_RESET);
         prio       = '0;
         row_width  = 32'(SCREEN_WIDTH_RESET);
         height     = '0;
         clear_idx  = '0;
         last_row   = 0;
         load_cursor();
         rearm();
         pixel_writes_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FORMAT_MODE:   fmt_amiga  = csr_write_data[0];
               CSR_START_X:       org_x      = 32'(csr_write_data);
               CSR_START_Y:       org_y      = 32'(csr_write_data);
               CSR_PORT_TOP:      top_row    = 32'(csr_write_data);
               CSR_PORT_BOTTOM:   bottom_row = 32'(csr_write_data);
               CSR_DRAW_PRIORITY: prio       = csr_write_data[7:0];
               CSR_SCREEN_WIDTH:  row_width  = 32'(csr_write_data);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expand_byte(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (pixel_writes_due.size() == 0) begin
               $error("pixel write at (%0d,%0d) with none due",
                      rsp_payload.pixel_x, rsp_payload.pixel_y);
               mismatches++;
            end else begin
               w = pixel_writes_due.pop_front();
               check_field("pixel_x", 32'(w.pixel_x), 32'(rsp_payload.pixel_x));
               check_field("pixel_y", 32'(w.pixel_y), 32'(rsp_payload.pixel_y));
               check_field("pixel_color", 32'(w.pixel_color),
                           32'(rsp_payload.pixel_color));
               check_field("pixel_priority", 32'(w.pixel_priority),
                           32'(rsp_payload.pixel_priority));
               check_field("run_end", 32'(w.run_end), 32'(rsp_payload.run_end));
            end
         end
      end
      writes_due = pixel_writes_due.size();
   end

endmodule

/* dv/rle_cel_pixel_expander_unit_test.sv */
// ----------------------------------------------------------------------------
// rle_cel_pixel_expander_unit_test - cel expander testbench
// Feeds an opening PC cel that walks through every run code, then coded cels
// with random content in both formats under several register settings,
// extremes included, with bursty requests and a randomly stalling receiver.
// The checker beside the block predicts and compares every pixel write.
// ----------------------------------------------------------------------------
module rle_cel_pixel_expander_unit_test;
   import rcpe_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int HANG_LIMIT    = 4000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_payload_type          req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_payload_type          rsp_payload;
   logic                     csr_write_enable = 1'b0;
   csr_index_type            csr_index = CSR_FORMAT_MODE;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;

   int mismatches;
   int writes_due;
   int burst_left = 0;
   int bytes_sent = 0;
   int stall_left = 0;
   int hang_count = 0;

   rle_cel_pixel_expander_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   rle_cel_pixel_write_checker pixel_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .writes_due       (writes_due)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: short stalls, long free stretches and choppy patches.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_stall  <= 1'b1;
               stall_left <= $urandom_range(1, 5);
            end
            1: begin
               rsp_stall  <= 1'b0;
               stall_left <= $urandom_range(20, 60);
            end
            default: begin
               rsp_stall  <= 1'($urandom_range(0, 1));
               stall_left <= $urandom_range(1, 4);
            end
         endcase
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
         $display("rle_cel_pixel_expander_unit: mismatch");
         $finish;
      end else begin
         hang_count <= hang_count + 1;
      end
   end

   // A burst always ends with a gap in which valid is low, so valid is
   // never lowered and raised in the same step.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(1, 8);
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: b, last_byte: is_last};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      burst_left--;
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   // Hold requests back until every pixel write due has come, then let the
   // block finish any request that writes nothing.
   task automatic settle();
      if (burst_left != 0) begin
         req_valid  <= 1'b0;
         burst_left = 0;
      end
      do @(negedge clock); while (writes_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic configure(input bit amiga, input logic [9:0] org_x,
                            input logic [9:0] org_y, input logic [9:0] top_row,
                            input logic [9:0] bottom_row, input logic [7:0] prio,
                            input logic [9:0] row_width);
      write_reg(CSR_FORMAT_MODE, {9'd0, amiga});
      write_reg(CSR_START_X, org_x);
      write_reg(CSR_START_Y, org_y);
      write_reg(CSR_PORT_TOP, top_row);
      write_reg(CSR_PORT_BOTTOM, bottom_row);
      write_reg(CSR_DRAW_PRIORITY, {2'b00, prio});
      write_reg(CSR_SCREEN_WIDTH, row_width);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly well-formed cels; some are cut short, left unterminated or are
   // plain noise.
   task automatic send_cel(input bit amiga);
      logic [7:0] body[$];
      logic [7:0] clear_idx;
      logic [7:0] b;
      int         n;
      int         cut;
      bit         closed;
      clear_idx = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                              : 8'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
      end else begin
         body.push_back(8'($urandom));
         body.push_back(8'($urandom));
         body.push_back(8'($urandom_range(1, 6)));
         body.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd0);
         body.push_back(8'($urandom));
         body.push_back(8'($urandom));
         body.push_back(clear_idx);
         body.push_back(8'($urandom));
         repeat ($urandom_range(2, 6)) begin
            if (amiga) begin
               b = 8'($urandom);
               if ($urandom_range(0, 2) == 0) b[2:0] = 3'd0;
               body.push_back(b);
            end else begin
               case ($urandom_range(0, 7))
                  0, 1, 2: begin
                     n = ($urandom_range(0, 11) == 0) ? $urandom_range(6, 20)
                                                      : $urandom_range(0, 4);
                     body.push_back({PC_LITERAL, 6'(n)});
                     repeat (n) body.push_back(($urandom_range(0, 3) == 0) ?
                                               clear_idx : 8'($urandom));
                  end
                  3, 4: begin
                     body.push_back({PC_FILL, 6'($urandom)});
                     body.push_back(8'($urandom));
                  end
                  5, 6: body.push_back({PC_SKIP, 6'($urandom)});
                  default: body.push_back({PC_UNUSED, 6'($urandom)});
               endcase
            end
         end
      end
      cut = body.size();
      if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, body.size());
      closed = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < cut; i++) send_byte(body[i], closed && (i == cut - 1));
   endtask

   initial begin
      // Opening cel: clear colour in a literal run, a full length fill with a
      // wrap, a full length skip, unused codes, empty literal and fill runs,
      // and a fill code as the last byte of the buffer.
      logic [7:0] opening_cel [22] = '{
         8'h00, 8'h00, 8'h02, 8'h00, 8'hFF, 8'h80, 8'h05, 8'h00,
         8'h03, 8'h05, 8'hFF, 8'h00,
         8'hBF, 8'hAA,
         8'hFF,
         8'h40, 8'h7F,
         8'h00,
         8'h80, 8'h33,
         8'hC0,
         8'h82
      };
      int          phase_start;
      int          quota;
      int unsigned row_width;
      int unsigned org_x;
      int unsigned org_y;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      configure(1'b0, 10'd60, 10'd3, 10'd2, 10'd200, 8'h5A, 10'd64);
      for (int i = 0; i < 22; i++) send_byte(opening_cel[i], i == 21);
      settle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            // Highest values; drawing starts at the far right column.
            0: configure(1'b1, 10'd1023, 10'd0, 10'd0, 10'd1023, 8'hFF, 10'd1023);
            // Start row saturates, so each cel is finished at its header.
            1: configure(1'b0, 10'd0, 10'd1023, 10'd1023, 10'd1023, 8'h00, 10'd64);
            // Lowest values; the row limit is zero.
            2: configure(1'b1, 10'd0, 10'd0, 10'd0, 10'd0, 8'h00, 10'd64);
            default: begin
               row_width = $urandom_range(64, 1023);
               org_x = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, row_width - 1);
               org_y = $urandom_range(0, 400);
               configure(1'(p), 10'(org_x), 10'(org_y), 10'($urandom_range(0, 100)),
                         ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                     : 10'($urandom_range(org_y + 1, 1023)),
                         8'($urandom), 10'(row_width));
            end
         endcase
         quota       = (p == 1 || p == 2) ? 6 : 10;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < quota) send_cel(p == 0 || p == 2 || p[0]);
         settle();
      end

      if (mismatches == 0 && writes_due == 0) begin
         $display("rle_cel_pixel_expander_unit: match");
      end else begin
         $display("rle_cel_pixel_expander_unit: mismatch");
      end
      $finish;
   end

endmodule
